// File: hw/rtl/tape_machine_instruction_step_macros.svh
// Assertion helpers used by tape_machine_instruction_step.sv.
`ifndef TAPE_MACHINE_INSTRUCTION_STEP_MACROS_SVH
`define TAPE_MACHINE_INSTRUCTION_STEP_MACROS_SVH

`ifndef SYNTHESIS

// ante true at an edge -> cons true at the same edge
`define TMIS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante true at an edge -> cons true at the next edge
`define TMIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TMIS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define TMIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/tmis_pkg.sv
package tmis_pkg;

   localparam int TAPE_SIZE_DEF = 4096;
   localparam int MAX_MOVES_DEF = 4;
   localparam int NUM_OFFSETS   = 4;

   localparam int PC_W     = 16;
   localparam int MODE_W   = 4;
   localparam int COUNT_W  = 16;
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 14;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_INC    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_DEC    = 4'd1;
   localparam logic [MODE_W-1:0] MODE_RIGHT  = 4'd2;
   localparam logic [MODE_W-1:0] MODE_LEFT   = 4'd3;
   localparam logic [MODE_W-1:0] MODE_OUTPUT = 4'd4;
   localparam logic [MODE_W-1:0] MODE_INPUT  = 4'd5;
   localparam logic [MODE_W-1:0] MODE_JFWD   = 4'd6;
   localparam logic [MODE_W-1:0] MODE_JBACK  = 4'd7;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 4'd8;
   localparam logic [MODE_W-1:0] MODE_MUL    = 4'd9;

   localparam logic [STATUS_W-1:0] STATUS_RUN    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BOUNDS = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_MUL_CHK,
      ST_MUL_RD,
      ST_MUL_WR,
      ST_MUL_CLR,
      ST_DONE
   } step_type;

   typedef enum logic [0:0] {
      RD_DP,
      RD_TARGET
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_EXEC,
      WR_TARGET,
      WR_ZERO,
      WR_SWEEP
   } wr_sel_type;

   typedef enum logic [2:0] {
      BR_GOTO,
      BR_ACCEPT,
      BR_DISPATCH,
      BR_MOVES,
      BR_OUT,
      BR_SWEEP
   } br_type;

   // branch: condition true -> next_step, false -> alt_step
   typedef struct packed {
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      br_type     br;
      step_type   next_step;
      step_type   alt_step;
   } ucode_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type uc;
      unique case (step)
         ST_CLEAR:   uc = '{RD_DP,     WR_SWEEP,  BR_SWEEP,    ST_IDLE,    ST_CLEAR};
         ST_IDLE:    uc = '{RD_DP,     WR_NONE,   BR_ACCEPT,   ST_EXEC,    ST_IDLE};
         ST_EXEC:    uc = '{RD_DP,     WR_EXEC,   BR_DISPATCH, ST_MUL_CHK, ST_DONE};
         ST_MUL_CHK: uc = '{RD_DP,     WR_NONE,   BR_MOVES,    ST_MUL_RD,  ST_MUL_CLR};
         ST_MUL_RD:  uc = '{RD_TARGET, WR_NONE,   BR_GOTO,     ST_MUL_WR,  ST_MUL_WR};
         ST_MUL_WR:  uc = '{RD_DP,     WR_TARGET, BR_GOTO,     ST_MUL_CHK, ST_MUL_CHK};
         ST_MUL_CLR: uc = '{RD_DP,     WR_ZERO,   BR_GOTO,     ST_DONE,    ST_DONE};
         ST_DONE:    uc = '{RD_DP,     WR_NONE,   BR_OUT,      ST_IDLE,    ST_DONE};
      endcase
      return uc;
   endfunction

endpackage

// File: hw/rtl/tmis_ram.sv
module tmis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tape_machine_instruction_step.sv
// Channel  Ports                                  Dir  Beat when
// req      req_valid/req_stall, req_mode..factor  in   req_valid & !req_stall
// rsp      rsp_valid/rsp_stall, rsp_next_pc..     out  rsp_valid & !rsp_stall
// csr      csr_wr_en, csr_wr_data                 in   csr_wr_en
//
// Plain modes run idle, execute and result steps; multiply-move adds a check,
// read and write step per move (n moves, at most MAX_MOVES), a last check and
// a clear step; one RAM port access per microcode step. After reset a clearing
// pass zeroes the tape with req_stall high; csr writes are taken at any time.
// The next beat is taken while a result waits in the output register; the
// result step holds until that register is free.
`include "tape_machine_instruction_step_macros.svh"

module tape_machine_instruction_step #(
   parameter int TAPE_SIZE = tmis_pkg::TAPE_SIZE_DEF,
   parameter int MAX_MOVES = tmis_pkg::MAX_MOVES_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_mode,
   input  logic [15:0] req_count,
   input  logic [7:0]  req_in_byte,
   input  logic signed [13:0] req_offset_a,
   input  logic signed [13:0] req_offset_b,
   input  logic signed [13:0] req_offset_c,
   input  logic signed [13:0] req_offset_d,
   input  logic [7:0]  req_factor_a,
   input  logic [7:0]  req_factor_b,
   input  logic [7:0]  req_factor_c,
   input  logic [7:0]  req_factor_d,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_next_pc,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_out_byte,
   output logic [15:0] rsp_out_repeat,

   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int ADDR_W = $clog2(TAPE_SIZE);
   localparam int CNT_W  = $clog2(MAX_MOVES + 1);
   localparam int IDX_W  = (MAX_MOVES > 1) ? $clog2(MAX_MOVES) : 1;
   localparam int SUM_W  = ((ADDR_W > tmis_pkg::OFFSET_W) ? ADDR_W : tmis_pkg::OFFSET_W) + 2;
   localparam int MV_W   = tmis_pkg::COUNT_W + 1;

   localparam logic [SUM_W-2:0]  TAPE_LIM  = (SUM_W-1)'(TAPE_SIZE);
   localparam logic [MV_W-1:0]   MV_LIM    = MV_W'(TAPE_SIZE);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TAPE_SIZE - 1);
   localparam logic [CNT_W-1:0]  MOVES_MAX = CNT_W'(MAX_MOVES);

   // sequencer
   tmis_pkg::step_type  step_ff, step_in;
   tmis_pkg::ucode_type uc;

   // control state
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] dp_ff, dp_in;
   logic [15:0]       pc_ff, pc_in;
   logic [15:0]       len_ff, len_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // captured beat and working registers
   logic [3:0]         mode_ff, mode_in;
   logic [15:0]        count_ff, count_in;
   logic [7:0]         inb_ff, inb_in;
   logic signed [13:0] off_ff [MAX_MOVES];
   logic signed [13:0] off_in [MAX_MOVES];
   logic [7:0]         fac_ff [MAX_MOVES];
   logic [7:0]         fac_in [MAX_MOVES];
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [7:0]         cell_ff, cell_in;
   logic [ADDR_W-1:0]  tgt_ff, tgt_in;
   logic [15:0]        res_pc_ff, res_pc_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [7:0]         res_byte_ff, res_byte_in;
   logic [15:0]        res_rep_ff, res_rep_in;
   logic [15:0]        rsp_pc_ff, rsp_pc_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic [15:0]        rsp_rep_ff, rsp_rep_in;

   logic signed [13:0] req_off_arr [tmis_pkg::NUM_OFFSETS];
   logic [7:0]         req_fac_arr [tmis_pkg::NUM_OFFSETS];

   // RAM port
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   // datapath
   logic              finished;
   logic              ex_wr;
   logic [7:0]        ex_data;
   logic [ADDR_W-1:0] ex_dp;
   logic [15:0]       ex_pc;
   logic              ex_bounds;
   logic [7:0]        ex_byte;
   logic [15:0]       ex_rep;
   logic              mul_go;
   logic              mul_fail;
   logic [MV_W-1:0]   mv_sum;
   logic signed [SUM_W-1:0] tsum [MAX_MOVES];
   logic [IDX_W-1:0]  k_idx;
   logic [ADDR_W-1:0] cur_tgt;
   logic [15:0]       prod;
   logic [7:0]        move_data;
   logic              out_free;
   logic              sweep_done;

   assign req_off_arr[0] = req_offset_a;
   assign req_off_arr[1] = req_offset_b;
   assign req_off_arr[2] = req_offset_c;
   assign req_off_arr[3] = req_offset_d;
   assign req_fac_arr[0] = req_factor_a;
   assign req_fac_arr[1] = req_factor_b;
   assign req_fac_arr[2] = req_factor_c;
   assign req_fac_arr[3] = req_factor_d;

   tmis_ram #(
      .WIDTH(8),
      .DEPTH(TAPE_SIZE)
   ) u_tape (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // control word for the current step
   always_comb begin
      uc = tmis_pkg::ucode_rom(step_ff);
   end

   assign req_stall  = (uc.br != tmis_pkg::BR_ACCEPT);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sweep_done = (clr_ff == LAST_ADDR);
   assign k_idx      = k_ff[IDX_W-1:0];

   // next step
   always_comb begin
      step_in = step_ff;
      unique case (uc.br)
         tmis_pkg::BR_GOTO:     step_in = uc.next_step;
         tmis_pkg::BR_ACCEPT:   step_in = req_valid  ? uc.next_step : uc.alt_step;
         tmis_pkg::BR_DISPATCH: step_in = mul_go     ? uc.next_step : uc.alt_step;
         tmis_pkg::BR_MOVES:    step_in = (k_ff < n_ff) ? uc.next_step : uc.alt_step;
         tmis_pkg::BR_OUT:      step_in = out_free   ? uc.next_step : uc.alt_step;
         tmis_pkg::BR_SWEEP:    step_in = sweep_done ? uc.next_step : uc.alt_step;
         default:               step_in = uc.next_step;
      endcase
   end

   // multiply targets, bounds checks
   always_comb begin
      mul_fail = 1'b0;
      for (int i = 0; i < MAX_MOVES; i++) begin
         tsum[i] = $signed(SUM_W'(dp_ff)) + SUM_W'(off_ff[i]);
         if ((CNT_W'(i) < n_ff) &&
             (tsum[i][SUM_W-1] || (tsum[i][SUM_W-2:0] >= TAPE_LIM))) begin
            mul_fail = 1'b1;
         end
      end
   end

   assign cur_tgt   = tsum[k_idx][ADDR_W-1:0];
   assign prod      = cell_ff * fac_ff[k_idx];
   assign move_data = ram_rd_data + prod[7:0];
   assign mv_sum    = MV_W'(dp_ff) + MV_W'(count_ff);
   assign finished  = (pc_ff >= len_ff);

   // instruction execute, cell value from the RAM read
   always_comb begin
      ex_wr     = 1'b0;
      ex_data   = ram_rd_data;
      ex_dp     = dp_ff;
      ex_pc     = pc_ff + 16'd1;
      ex_bounds = 1'b0;
      ex_byte   = 8'd0;
      ex_rep    = 16'd0;
      mul_go    = 1'b0;
      if (!finished) begin
         unique case (mode_ff)
            tmis_pkg::MODE_INC: begin
               ex_wr   = 1'b1;
               ex_data = ram_rd_data + count_ff[7:0];
            end
            tmis_pkg::MODE_DEC: begin
               ex_wr   = 1'b1;
               ex_data = ram_rd_data - count_ff[7:0];
            end
            tmis_pkg::MODE_RIGHT: begin
               if (mv_sum >= MV_LIM) begin
                  ex_bounds = 1'b1;
               end else begin
                  ex_dp = mv_sum[ADDR_W-1:0];
               end
            end
            tmis_pkg::MODE_LEFT: begin
               if (MV_W'(count_ff) > MV_W'(dp_ff)) begin
                  ex_bounds = 1'b1;
               end else begin
                  ex_dp = dp_ff - ADDR_W'(count_ff);
               end
            end
            tmis_pkg::MODE_OUTPUT: begin
               ex_byte = ram_rd_data;
               ex_rep  = count_ff;
            end
            tmis_pkg::MODE_INPUT: begin
               ex_wr   = (count_ff != 16'd0);
               ex_data = inb_ff;
            end
            tmis_pkg::MODE_JFWD: begin
               if (ram_rd_data == 8'd0) begin
                  ex_pc = count_ff + 16'd1;
               end
            end
            tmis_pkg::MODE_JBACK: begin
               if (ram_rd_data != 8'd0) begin
                  ex_pc = count_ff + 16'd1;
               end
            end
            tmis_pkg::MODE_CLEAR: begin
               ex_wr   = 1'b1;
               ex_data = 8'd0;
            end
            tmis_pkg::MODE_MUL: begin
               if (mul_fail) begin
                  ex_bounds = 1'b1;
               end else begin
                  mul_go = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // RAM port selection
   always_comb begin
      ram_rd_addr = (uc.rd_sel == tmis_pkg::RD_TARGET) ? cur_tgt : dp_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = dp_ff;
      ram_wr_data = 8'd0;
      unique case (uc.wr_sel)
         tmis_pkg::WR_NONE: begin
         end
         tmis_pkg::WR_EXEC: begin
            ram_wr_en   = ex_wr;
            ram_wr_data = ex_data;
         end
         tmis_pkg::WR_TARGET: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = tgt_ff;
            ram_wr_data = move_data;
         end
         tmis_pkg::WR_ZERO: begin
            ram_wr_en = 1'b1;
         end
         tmis_pkg::WR_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
         end
         default: begin
         end
      endcase
   end

   // register next values
   always_comb begin
      clr_in        = clr_ff;
      dp_in         = dp_ff;
      pc_in         = pc_ff;
      len_in        = csr_wr_en ? csr_wr_data : len_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      inb_in        = inb_ff;
      off_in        = off_ff;
      fac_in        = fac_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      cell_in       = cell_ff;
      tgt_in        = tgt_ff;
      res_pc_in     = res_pc_ff;
      res_status_in = res_status_ff;
      res_byte_in   = res_byte_ff;
      res_rep_in    = res_rep_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_rep_in    = rsp_rep_ff;

      if (uc.wr_sel == tmis_pkg::WR_SWEEP) begin
         clr_in = clr_ff + ADDR_W'(1);
      end

      if (uc.br == tmis_pkg::BR_ACCEPT && req_valid) begin
         mode_in  = req_mode;
         count_in = req_count;
         inb_in   = req_in_byte;
         for (int i = 0; i < MAX_MOVES; i++) begin
            off_in[i] = req_off_arr[i];
            fac_in[i] = req_fac_arr[i];
         end
         n_in = (req_count > 16'(MAX_MOVES)) ? MOVES_MAX : req_count[CNT_W-1:0];
      end

      if (uc.wr_sel == tmis_pkg::WR_EXEC) begin
         cell_in = ram_rd_data;
         k_in    = '0;
         if (finished) begin
            res_pc_in     = pc_ff;
            res_status_in = tmis_pkg::STATUS_DONE;
            res_byte_in   = 8'd0;
            res_rep_in    = 16'd0;
         end else if (ex_bounds) begin
            res_pc_in     = pc_ff;
            res_status_in = tmis_pkg::STATUS_BOUNDS;
            res_byte_in   = 8'd0;
            res_rep_in    = 16'd0;
         end else begin
            dp_in         = ex_dp;
            pc_in         = ex_pc;
            res_pc_in     = ex_pc;
            res_status_in = (ex_pc >= len_ff) ? tmis_pkg::STATUS_DONE : tmis_pkg::STATUS_RUN;
            res_byte_in   = ex_byte;
            res_rep_in    = ex_rep;
         end
      end

      if (uc.rd_sel == tmis_pkg::RD_TARGET) begin
         tgt_in = cur_tgt;
      end

      // a target on the current cell changes what later moves see
      if (uc.wr_sel == tmis_pkg::WR_TARGET) begin
         k_in = k_ff + CNT_W'(1);
         if (tgt_ff == dp_ff) begin
            cell_in = move_data;
         end
      end

      if (uc.br == tmis_pkg::BR_OUT && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_pc_in     = res_pc_ff;
         rsp_status_in = res_status_ff;
         rsp_byte_in   = res_byte_ff;
         rsp_rep_in    = res_rep_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= tmis_pkg::ST_CLEAR;
         clr_ff       <= '0;
         dp_ff        <= '0;
         pc_ff        <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         dp_ff        <= dp_in;
         pc_ff        <= pc_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      count_ff      <= count_in;
      inb_ff        <= inb_in;
      off_ff        <= off_in;
      fac_ff        <= fac_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      cell_ff       <= cell_in;
      tgt_ff        <= tgt_in;
      res_pc_ff     <= res_pc_in;
      res_status_ff <= res_status_in;
      res_byte_ff   <= res_byte_in;
      res_rep_ff    <= res_rep_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_rep_ff    <= rsp_rep_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_pc    = rsp_pc_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_out_repeat = rsp_rep_ff;

   `TMIS_ASSERT_IMPL(a_wr_addr_range, clock, reset, ram_wr_en, ram_wr_addr <= LAST_ADDR, "tape write past end")
   `TMIS_ASSERT_IMPL(a_dp_range, clock, reset, 1'b1, dp_ff <= LAST_ADDR, "data pointer past tape end")
   `TMIS_ASSERT_IMPL(a_move_index, clock, reset, step_ff == tmis_pkg::ST_MUL_RD, k_ff < n_ff, "move index beyond move count")
   `TMIS_ASSERT_NEXT(a_pc_hold, clock, reset, !reset && step_ff != tmis_pkg::ST_EXEC, $stable(pc_ff), "pc changed outside execute")
   `TMIS_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(step_ff == tmis_pkg::ST_DONE), "response without result step")

endmodule
